### hw/rtl/gregorian_date_offset_defines.svh
// Assertion macros for the date offset top level.
`ifndef GREGORIAN_DATE_OFFSET_DEFINES_SVH
`define GREGORIAN_DATE_OFFSET_DEFINES_SVH

// Check that cond implies prop at every clock edge outside reset.
`define GDO_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("date offset check failed");

// Check that cond never holds outside reset.
`define GDO_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("date offset forbidden condition seen");

`endif

### hw/rtl/gdo_pkg.sv
// Types, constants and tables for the Gregorian date offset block.
`default_nettype none
package gdo_pkg;

  localparam int OFFSET_PORT_W = 32;
  localparam int Z_W           = 22;
  localparam int SERIAL_W      = 25;

  // Day numbers of 0001-01-01 and 9999-12-31 (years shifted by 400).
  localparam int DAY_LO = 146403;
  localparam int DAY_HI = 3798461;

  // Reciprocals for exact constant division: q = (x * M) >> K.
  localparam logic [13:0] DIV25_M    = 14'(((64'd1 << 18) + 64'd24) / 64'd25);
  localparam logic [22:0] DIVERA_M   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [22:0] DIV7_M     = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
  localparam logic [18:0] DIV1460_M  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] DIV36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] DIV146096_M = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
  localparam logic [18:0] DIV365_M   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  DIV100_M   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [12:0] DIV153_M   = 13'(((64'd1 << 20) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [13:0]                     start_year;
    logic [3:0]                      start_month;
    logic [4:0]                      start_day;
    logic signed [OFFSET_PORT_W-1:0] day_offset;
  } gdo_in_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [2:0]  weekday;
    logic        out_of_range;
  } gdo_out_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } gdo_date_t;

  typedef struct packed {
    logic      oor;
    gdo_date_t echo;
  } gdo_meta_t;

  typedef struct packed {
    logic [Z_W-1:0] z;
    gdo_meta_t      meta;
  } gdo_ser_t;

  // Days from March 1 to the first of month index mp (March = 0).
  function automatic logic [8:0] cum_days(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/gdo_to_serial.sv
// Front pipeline: date to day number, add offset, range check.
`default_nettype none
module gdo_to_serial import gdo_pkg::*; #(
  parameter int OFFSET_WIDTH = 21
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     in_valid,
  input  wire gdo_in_t  in_item,
  output logic          ser_valid,
  output gdo_ser_t      ser_item
);

  localparam int RW = ((OFFSET_WIDTH > SERIAL_W) ? OFFSET_WIDTH : SERIAL_W) + 1;

  // stage 1
  logic [3:0]             mon_c, mp_c;
  logic                   early_c;
  logic                   v1_r;
  logic [14:0]            yy1_r, yy1_nxt;
  logic signed [10:0]     doy1_r, doy1_nxt;
  logic signed [RW-1:0]   off1_r, off1_nxt;
  gdo_meta_t              meta1_r, meta1_nxt;
  // stage 2
  logic                   v2_r;
  logic [22:0]            y365_2_r;
  logic [12:0]            q4_2_r;
  logic [26:0]            p100_2_r, p400_2_r;
  logic signed [10:0]     doy2_r;
  logic signed [RW-1:0]   off2_r;
  gdo_meta_t              meta2_r;
  // stage 3
  logic                   v3_r;
  logic signed [SERIAL_W-1:0] serial3_r, serial3_nxt;
  logic signed [RW-1:0]   off3_r;
  gdo_meta_t              meta3_r;
  // stage 4
  logic signed [RW-1:0]   r_c;
  logic                   oor_c;

  always_comb begin
    if (in_item.start_month == 4'd0) begin
      mon_c = 4'd1;
    end else if (in_item.start_month > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = in_item.start_month;
    end
    early_c  = (mon_c <= 4'd2);
    mp_c     = early_c ? (mon_c + 4'd9) : (mon_c - 4'd3);
    yy1_nxt  = 15'(in_item.start_year) + 15'd400 - 15'(early_c);
    doy1_nxt = $signed({2'b00, cum_days(mp_c)}) + $signed({6'b0, in_item.start_day})
               - 11'sd1;
    off1_nxt = RW'($signed(in_item.day_offset[OFFSET_WIDTH-1:0]));
    meta1_nxt.oor        = 1'b0;
    meta1_nxt.echo.year  = in_item.start_year;
    meta1_nxt.echo.month = mon_c;
    meta1_nxt.echo.day   = in_item.start_day;
  end

  assign serial3_nxt = $signed({2'b00, y365_2_r}) + $signed({12'b0, q4_2_r})
                     - $signed({17'b0, p100_2_r[25:18]}) + $signed({19'b0, p400_2_r[23:18]})
                     + SERIAL_W'(doy2_r);

  always_comb begin
    r_c   = RW'(serial3_r) + off3_r;
    oor_c = (r_c < $signed(RW'(DAY_LO))) || (r_c > $signed(RW'(DAY_HI)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      ser_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      ser_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yy1_r    <= yy1_nxt;
      doy1_r   <= doy1_nxt;
      off1_r   <= off1_nxt;
      meta1_r  <= meta1_nxt;

      y365_2_r <= 23'(yy1_r) * 23'd365;
      q4_2_r   <= 13'(yy1_r >> 2);
      p100_2_r <= 27'(yy1_r >> 2) * 27'(DIV25_M);
      p400_2_r <= 27'(yy1_r >> 4) * 27'(DIV25_M);
      doy2_r   <= doy1_r;
      off2_r   <= off1_r;
      meta2_r  <= meta1_r;

      serial3_r <= serial3_nxt;
      off3_r    <= off2_r;
      meta3_r   <= meta2_r;

      ser_item.z         <= r_c[Z_W-1:0];
      ser_item.meta.oor  <= oor_c;
      ser_item.meta.echo <= meta3_r.echo;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gdo_from_serial.sv
// Back pipeline: day number to date and weekday, with out-of-range echo.
`default_nettype none
module gdo_from_serial import gdo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     ser_valid,
  input  wire gdo_ser_t ser_item,
  output logic          out_valid,
  output gdo_out_t      out_item
);

  logic [11:0]    v_r;
  gdo_meta_t      m_r [11];

  logic [44:0]    pe1_r, pw1_r;
  logic [Z_W-1:0] z1_r, z2_r;
  logic [4:0]     era2_r, era3_r;
  logic [19:0]    q7_2_r;
  logic [17:0]    doe3_r, doe4_r, doe5_r, doe6_r, doe7_r, doe8_r;
  logic [2:0]     wd3_r, wd4_r, wd5_r, wd6_r, wd7_r, wd8_r, wd9_r, wd10_r, wd11_r;
  logic [14:0]    e400_4_r, e400_5_r, e400_6_r, e400_7_r, e400_8_r, e400_9_r,
                  e400_10_r, e400_11_r;
  logic [36:0]    a4_r, b4_r, c4_r;
  logic [17:0]    t5_r;
  logic [36:0]    pt6_r;
  logic [8:0]     yoe7_r, yoe8_r, yoe9_r, yoe10_r, yoe11_r;
  logic [17:0]    y365_8_r;
  logic [18:0]    py100_8_r;
  logic [8:0]     doy9_r, doy10_r, doy11_r;
  logic [24:0]    pm10_r;
  logic [3:0]     mp11_r;

  logic [21:0]    x7_c;
  logic [3:0]     mon_c;
  logic [14:0]    year_c;
  gdo_out_t       out_nxt;

  assign x7_c = z2_r + 22'd3;

  always_comb begin
    mon_c  = (mp11_r < 4'd10) ? (mp11_r + 4'd3) : (mp11_r - 4'd9);
    year_c = 15'(yoe11_r) + e400_11_r + 15'(mon_c <= 4'd2) - 15'd400;
    if (m_r[10].oor) begin
      out_nxt.result_year  = m_r[10].echo.year;
      out_nxt.result_month = m_r[10].echo.month;
      out_nxt.result_day   = m_r[10].echo.day;
      out_nxt.weekday      = 3'd0;
      out_nxt.out_of_range = 1'b1;
    end else begin
      out_nxt.result_year  = year_c[13:0];
      out_nxt.result_month = mon_c;
      out_nxt.result_day   = 5'(doy11_r - cum_days(mp11_r) + 9'd1);
      out_nxt.weekday      = wd11_r;
      out_nxt.out_of_range = 1'b0;
    end
  end

  assign out_valid = v_r[11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[10:0], ser_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= ser_item.meta;
      for (int i = 1; i < 11; i++) begin
        m_r[i] <= m_r[i-1];
      end
      // era and weekday quotients
      pe1_r <= 45'(ser_item.z) * 45'(DIVERA_M);
      pw1_r <= 45'(ser_item.z + 22'd3) * 45'(DIV7_M);
      z1_r  <= ser_item.z;
      era2_r <= pe1_r[44:40];
      q7_2_r <= pw1_r[44:25];
      z2_r   <= z1_r;
      // day of era, weekday remainder
      doe3_r <= 18'(z2_r - 22'(era2_r) * 22'd146097);
      wd3_r  <= 3'(x7_c - 22'(q7_2_r) * 22'd7);
      era3_r <= era2_r;
      // leap corrections
      a4_r     <= 37'(doe3_r) * 37'(DIV1460_M);
      b4_r     <= 37'(doe3_r) * 37'(DIV36524_M);
      c4_r     <= 37'(doe3_r) * 37'(DIV146096_M);
      doe4_r   <= doe3_r;
      wd4_r    <= wd3_r;
      e400_4_r <= 15'(era3_r) * 15'd400;
      t5_r     <= doe4_r - 18'(a4_r[36:29]) + 18'(b4_r[36:34]) - 18'(c4_r[36]);
      doe5_r   <= doe4_r;
      wd5_r    <= wd4_r;
      e400_5_r <= e400_4_r;
      // year of era
      pt6_r    <= 37'(t5_r) * 37'(DIV365_M);
      doe6_r   <= doe5_r;
      wd6_r    <= wd5_r;
      e400_6_r <= e400_5_r;
      yoe7_r   <= pt6_r[35:27];
      doe7_r   <= doe6_r;
      wd7_r    <= wd6_r;
      e400_7_r <= e400_6_r;
      // day of year
      y365_8_r  <= 18'(yoe7_r) * 18'd365;
      py100_8_r <= 19'(yoe7_r) * 19'(DIV100_M);
      yoe8_r    <= yoe7_r;
      doe8_r    <= doe7_r;
      wd8_r     <= wd7_r;
      e400_8_r  <= e400_7_r;
      doy9_r    <= 9'(doe8_r - (y365_8_r + 18'(yoe8_r >> 2) - 18'(py100_8_r[18:16])));
      yoe9_r    <= yoe8_r;
      wd9_r     <= wd8_r;
      e400_9_r  <= e400_8_r;
      // month index
      pm10_r    <= (25'(doy9_r) * 25'd5 + 25'd2) * 25'(DIV153_M);
      doy10_r   <= doy9_r;
      yoe10_r   <= yoe9_r;
      wd10_r    <= wd9_r;
      e400_10_r <= e400_9_r;
      mp11_r    <= pm10_r[23:20];
      doy11_r   <= doy10_r;
      yoe11_r   <= yoe10_r;
      wd11_r    <= wd10_r;
      e400_11_r <= e400_10_r;
      out_item  <= out_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gregorian_date_offset.sv
// Top level of the Gregorian date offset block.
`default_nettype none
`include "gregorian_date_offset_defines.svh"
// Moves a Gregorian date by a signed day count and returns the new date and
// its weekday (0 = Sunday). The start date becomes a linear day number, the
// offset (low OFFSET_WIDTH bits of in_item.day_offset, sign-extended) is
// added, and the sum is turned back into year, month and day with exact
// reciprocal multiplies in place of the constant divisions. Month 0 reads as
// January and 13..15 as December; day 0 and days past the month end count on
// linearly. A result outside 0001-01-01..9999-12-31 sets out_of_range, echoes
// the start date and reports weekday 0. Timing: a 16-stage pipeline; one item
// enters per cycle while the output is not stalled. The whole pipeline
// freezes while a waiting result is stalled, so in_stall follows out_valid
// and out_stall.
module gregorian_date_offset import gdo_pkg::*; #(
  parameter int OFFSET_WIDTH = 21
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire gdo_in_t in_item,
  output logic         out_valid,
  input  wire logic    out_stall,
  output gdo_out_t     out_item
);

  logic     adv;
  logic     ser_valid;
  gdo_ser_t ser_item;

  // Advance every stage unless the finished item is held at the output.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  gdo_to_serial #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_to_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .ser_valid (ser_valid),
    .ser_item  (ser_item)
  );

  gdo_from_serial u_from_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ser_valid (ser_valid),
    .ser_item  (ser_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Out-of-range items report Sunday and a clamped month.
  `GDO_ASSERT_IMPLY(a_oor_weekday, out_valid && out_item.out_of_range, out_item.weekday == 3'd0)
  `GDO_ASSERT_IMPLY(a_oor_month, out_valid && out_item.out_of_range, out_item.result_month >= 4'd1 && out_item.result_month <= 4'd12)
  // A converted date always has a real month, day and weekday.
  `GDO_ASSERT_NEVER(a_bad_date, out_valid && !out_item.out_of_range && (out_item.result_month == 4'd0 || out_item.result_month > 4'd12 || out_item.result_day == 5'd0 || out_item.weekday > 3'd6))

endmodule
`default_nettype wire

### tb/gregorian_date_offset_test.sv
// Testbench for gregorian_date_offset: directed table, then random dates checked by a predictor.
module gregorian_date_offset_test;
  import gdo_pkg::*;

  localparam int OFF_W      = 21;
  localparam int PIPE_DEPTH = 16;
  localparam int RAND_ITEMS = 1800;
  localparam int IDLE_LIMIT = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gdo_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gdo_out_t out_item;

  gregorian_date_offset #(.OFFSET_WIDTH(OFF_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // Dates still inside the pipeline, oldest first.
  gdo_out_t pending_dates[$];
  int  errors = 0;
  int  dates_out = 0;
  int  range_flags = 0;
  int  idle_cycles = 0;
  int  sent_count = 0;
  bit  sending_done = 1'b0;

  // Linear day number, years shifted by 400 so that it stays non-negative.
  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy;
    yy  = y + 400 - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  // Work out the shifted date and its weekday for one item.
  function automatic gdo_out_t shift_date(gdo_in_t it);
    gdo_out_t r;
    logic signed [OFF_W-1:0] raw;
    longint sy, sm, sd, z, era, doe, yoe, doy, mp, ry, rm, rd, zy, zm;
    sy  = it.start_year;
    sm  = it.start_month;
    sd  = it.start_day;
    raw = it.day_offset[OFF_W-1:0];
    // Clamp the month before anything else; the echo uses the clamped value.
    if (sm < 1) sm = 1;
    if (sm > 12) sm = 12;
    z = day_number(sy, sm, sd) + longint'(raw);
    if (z < day_number(1, 1, 1) || z > day_number(9999, 12, 31)) begin
      r.result_year  = 14'(sy);
      r.result_month = 4'(sm);
      r.result_day   = 5'(sd);
      r.weekday      = 3'd0;
      r.out_of_range = 1'b1;
      return r;
    end
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    rm  = (mp < 10) ? (mp + 3) : (mp - 9);
    rd  = doy - (153 * mp + 2) / 5 + 1;
    ry  = yoe + era * 400 + ((rm <= 2) ? 1 : 0) - 400;
    // Zeller: January and February count as months 13 and 14 of the year before.
    zy = ry;
    zm = rm;
    if (zm <= 2) begin
      zy = zy - 1;
      zm = zm + 12;
    end
    r.result_year  = 14'(ry);
    r.result_month = 4'(rm);
    r.result_day   = 5'(rd);
    r.weekday      = 3'((zy + zy / 4 - zy / 100 + zy / 400 + (13 * zm + 8) / 5 + rd) % 7);
    r.out_of_range = 1'b0;
    return r;
  endfunction

  function automatic gdo_in_t make_item(int y, int m, int d, logic [31:0] off);
    gdo_in_t it;
    it.start_year  = 14'(y);
    it.start_month = 4'(m);
    it.start_day   = 5'(d);
    it.day_offset  = off;
    return it;
  endfunction

  function automatic gdo_out_t make_date(int y, int m, int d, int wd, bit oor);
    gdo_out_t r;
    r.result_year  = 14'(y);
    r.result_month = 4'(m);
    r.result_day   = 5'(d);
    r.weekday      = 3'(wd);
    r.out_of_range = oor;
    return r;
  endfunction

  // Random item: mostly legal dates and modest offsets, some edge years and junk.
  function automatic gdo_in_t random_item();
    gdo_in_t it;
    logic [31:0] off;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)       it.start_year = 14'($urandom_range(1, 9999));
    else if (pick < 8)  it.start_year = 14'($urandom_range(1, 3));
    else if (pick < 9)  it.start_year = 14'($urandom_range(9997, 9999));
    else                it.start_year = 14'($urandom_range(0, 16383));
    it.start_month = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 12));
    it.start_day = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 28));
    // Upper port bits are random garbage; only the low OFF_W bits count.
    off = $urandom;
    case ($urandom_range(0, 2))
      0:       off[OFF_W-1:0] = OFF_W'($urandom_range(0, 800) - 400);
      1:       off[OFF_W-1:0] = OFF_W'($urandom_range(0, 80000) - 40000);
      default: ;
    endcase
    it.day_offset = off;
    return it;
  endfunction

  // Receiver: random hold-off per item, one long hold to fill the pipeline,
  // and a run of back-to-back accepts with no hold at all.
  int hold_left = 0;
  int taken = 0;
  always begin
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      taken++;
      if (taken == 301) hold_left = 120;
      else if (taken > 900 && taken <= 1100) hold_left = 0;
      else hold_left = $urandom_range(0, 4);
      if (hold_left > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold_left) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result against the oldest pending date.
  always @(posedge clk) begin
    gdo_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      dates_out <= dates_out + 1;
      if (pending_dates.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected result %p", $time, out_item);
      end else begin
        want = pending_dates.pop_front();
        if (out_item.out_of_range) range_flags <= range_flags + 1;
        if (out_item !== want) begin
          errors <= errors + 1;
          $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
        end
      end
    end
  end

  // Watchdog: stop if neither side moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (rst_n && (!sending_done || pending_dates.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one item, hold it until taken, log its expected date, then idle for a random gap, which may be zero.
  task automatic offer_date(gdo_in_t it, bit typed, gdo_out_t want);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(typed ? want : shift_date(it));
    sent_count++;
    gap = (sent_count >= 1200 && sent_count < 1400) ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  typedef struct {
    gdo_in_t  it;
    bit       typed;
    gdo_out_t want;
  } date_row_t;

  date_row_t rows[$];
  gdo_out_t  none;

  initial begin
    none = '0;
    // Extremes of the legal range; weekdays known by heart.
    rows.push_back('{make_item(1, 1, 1, 0), 1, make_date(1, 1, 1, 1, 0)});
    rows.push_back('{make_item(1, 1, 1, -1), 1, make_date(1, 1, 1, 0, 1)});
    rows.push_back('{make_item(9999, 12, 31, 0), 1, make_date(9999, 12, 31, 5, 0)});
    rows.push_back('{make_item(9999, 12, 31, 1), 1, make_date(9999, 12, 31, 0, 1)});
    rows.push_back('{make_item(2000, 1, 1, 0), 1, make_date(2000, 1, 1, 6, 0)});
    // Far out-of-range start year echoes with the month clamped to December.
    rows.push_back('{make_item(16383, 15, 31, 5), 1, make_date(16383, 12, 31, 0, 1)});
    // Leap rule: 2000 leap, 1900 not, 2100 not.
    rows.push_back('{make_item(2000, 2, 28, 1), 0, none});
    rows.push_back('{make_item(1900, 2, 28, 1), 0, none});
    rows.push_back('{make_item(2100, 2, 29, 0), 0, none});
    rows.push_back('{make_item(2024, 3, 1, -1), 0, none});
    // Month zero and months above twelve.
    rows.push_back('{make_item(2020, 0, 15, 0), 0, none});
    rows.push_back('{make_item(2020, 13, 15, 10), 0, none});
    // Day zero and days past the month end.
    rows.push_back('{make_item(2021, 3, 0, 0), 0, none});
    rows.push_back('{make_item(2021, 2, 31, 0), 0, none});
    // Year zero start comes back into range.
    rows.push_back('{make_item(0, 6, 1, 366), 0, none});
    // Offset extremes and garbage in the upper port bits.
    rows.push_back('{make_item(5000, 6, 15, 32'h000F_FFFF), 0, none});
    rows.push_back('{make_item(5000, 6, 15, 32'hFFF0_0000), 0, none});
    rows.push_back('{make_item(5000, 6, 15, 32'hFFE0_0005), 0, none});
    rows.push_back('{make_item(1, 3, 1, 32'h0010_0000), 0, none});
    rows.push_back('{make_item(9999, 1, 1, 32'h000F_FFFF), 0, none});

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) offer_date(rows[i].it, rows[i].typed, rows[i].want);
    repeat (RAND_ITEMS) offer_date(random_item(), 0, none);
    in_valid <= 1'b0;
    sending_done = 1'b1;

    wait (pending_dates.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Moved %0d dates, checked %0d (%0d out of range), leap years, clamps and extremes.",
             sent_count, dates_out, range_flags);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gdo_pkg.sv
hw/rtl/gdo_to_serial.sv
hw/rtl/gdo_from_serial.sv
hw/rtl/gregorian_date_offset.sv
tb/gregorian_date_offset_test.sv
